// File: src/sdsg_pkg.sv
// Shared types, codes and reset values for the shutter drive stall guard.
package sdsg_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int TIMEOUT_W      = 32;
  localparam int LIMIT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int OUT_W          = 16;

  // Drive direction codes
  localparam logic [1:0] DIR_STOP  = 2'd0;
  localparam logic [1:0] DIR_OPEN  = 2'd1;
  localparam logic [1:0] DIR_CLOSE = 2'd2;

  // Limit switch codes
  localparam logic [1:0] LIM_OPEN    = 2'd0;
  localparam logic [1:0] LIM_CLOSED  = 2'd1;
  localparam logic [1:0] LIM_UNKNOWN = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT     = 2'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd10000;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 4'd3;
  localparam logic [LIMIT_W-1:0]   RETRY_MAX   = 4'd15;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] arrival_timeout;
    logic [LIMIT_W-1:0]   retry_limit;
  } cfg_t;

  typedef struct packed {
    logic                latched;
    logic [LIMIT_W-1:0]  stall_retries;
    logic [7:0]          drive_duty;
    logic [1:0]          drive_direction;
  } res_t;

  function automatic logic at_end(input logic [1:0] dir, input logic [1:0] lim);
    at_end = (dir == DIR_OPEN && lim == LIM_OPEN) ||
             (dir == DIR_CLOSE && lim == LIM_CLOSED);
  endfunction

endpackage

// File: src/shutter_drive_stall_guard.sv
// Top level of the shutter drive stall guard: stream ports, beat registers and guard.
// The guard is one pass of compare and subtract logic. An accepted poll waits in the
// input beat register, then enters the result register when that is empty or draining.
// Throughput: one poll per cycle, unless a stalled result side holds the polls back.
// Reset (rst_n, synchronous, active low): both beat registers empty, direction stop,
// window start and retry count zero, timeout 10000 ms and retry limit 3.
module shutter_drive_stall_guard #(
  parameter int TIME_WIDTH = sdsg_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Poll beats. tdata from bit 0: dir_cmd[7:0], duty[7:0], limit_state[1:0],
  // now_time[TIME_WIDTH-1:0], zero padding to a whole byte.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((18 + TIME_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // Result beats. tdata from bit 0: drive_direction[1:0], drive_duty[7:0],
  // stall_retries[3:0], latched, one bit of zero padding.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sdsg_pkg::OUT_W-1:0]          out_tdata,
  // Configuration writes: index 0 arrival_timeout, index 1 retry_limit.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sdsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IN_W = ((18 + TIME_WIDTH + 7) / 8) * 8;

  sdsg_pkg::cfg_t cfg;
  sdsg_pkg::res_t res;

  logic                        in_valid_r;
  logic [IN_W-1:0]             in_data_r;
  logic                        out_valid_r;
  logic [sdsg_pkg::OUT_W-1:0]  out_data_r;
  logic                        advance;

  // The result register may take a new beat when it is empty or being drained;
  // the input register refills whenever its content moves on.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  sdsg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The guard state moves exactly once per poll, as the poll enters the result register.
  sdsg_guard #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_guard (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_valid_r && advance),
    .dir_cmd       (in_data_r[7:0]),
    .duty          (in_data_r[15:8]),
    .limit_state   (in_data_r[17:16]),
    .now_time      (in_data_r[18 +: TIME_WIDTH]),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (in_valid_r && advance) begin
      out_data_r <= {1'b0, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/sdsg_cfg.sv
// Configuration register file: arrival timeout and retry limit.
module sdsg_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sdsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdsg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sdsg_pkg::cfg_t                    cfg
);

  sdsg_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arrival_timeout <= sdsg_pkg::TIMEOUT_RST;
      cfg_r.retry_limit     <= sdsg_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdsg_pkg::CFG_ARRIVAL_TIMEOUT: begin
          cfg_r.arrival_timeout <= cfg_data[sdsg_pkg::TIMEOUT_W-1:0];
        end
        sdsg_pkg::CFG_RETRY_LIMIT: begin
          cfg_r.retry_limit <= cfg_data[sdsg_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/sdsg_guard.sv
// Stall guard state and the per-poll decision logic.
module sdsg_guard #(
  parameter int TIME_WIDTH = sdsg_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             dir_cmd,
  input  logic [7:0]             duty,
  input  logic [1:0]             limit_state,
  input  logic [TIME_WIDTH-1:0]  now_time,
  input  sdsg_pkg::cfg_t         cfg,
  output sdsg_pkg::res_t         res
);

  localparam int CMP_W = (TIME_WIDTH > sdsg_pkg::TIMEOUT_W) ? TIME_WIDTH : sdsg_pkg::TIMEOUT_W;

  logic [1:0]                    active_dir_r, active_dir_nxt;
  logic [TIME_WIDTH-1:0]         window_start_r, window_start_nxt;
  logic [sdsg_pkg::LIMIT_W-1:0]  retries_r, retries_nxt;

  logic [1:0]                    req, cdir, odir;
  logic [7:0]                    cduty, oduty;
  logic [TIME_WIDTH-1:0]         elapsed;
  logic                          timed_out;
  logic                          latched_pre;
  logic [sdsg_pkg::LIMIT_W-1:0]  retries_inc;

  always_comb begin
    if (dir_cmd == 8'd0) begin
      req = sdsg_pkg::DIR_STOP;
    end else if (dir_cmd[7]) begin
      req = sdsg_pkg::DIR_CLOSE;
    end else begin
      req = sdsg_pkg::DIR_OPEN;
    end

    cdir  = req;
    cduty = duty;
    if (req == sdsg_pkg::DIR_STOP || duty == 8'd0 ||
        limit_state == sdsg_pkg::LIM_UNKNOWN || sdsg_pkg::at_end(req, limit_state)) begin
      cdir  = sdsg_pkg::DIR_STOP;
      cduty = 8'd0;
    end

    elapsed     = now_time - window_start_r;
    timed_out   = CMP_W'(elapsed) >= CMP_W'(cfg.arrival_timeout);
    latched_pre = retries_r >= cfg.retry_limit;
    retries_inc = (retries_r == sdsg_pkg::RETRY_MAX) ? retries_r
                                                     : retries_r + sdsg_pkg::LIMIT_W'(1);

    active_dir_nxt   = active_dir_r;
    window_start_nxt = window_start_r;
    retries_nxt      = retries_r;
    odir             = sdsg_pkg::DIR_STOP;
    oduty            = 8'd0;

    if (cdir != active_dir_r) begin
      if (cdir != sdsg_pkg::DIR_STOP || sdsg_pkg::at_end(active_dir_r, limit_state)) begin
        // New direction taken over: fresh window, retries cleared.
        active_dir_nxt   = cdir;
        window_start_nxt = now_time;
        retries_nxt      = '0;
        odir             = cdir;
        oduty            = cduty;
      end else if (limit_state == sdsg_pkg::LIM_UNKNOWN) begin
        if (!latched_pre && timed_out) begin
          retries_nxt      = retries_inc;
          window_start_nxt = now_time;
        end
      end else begin
        window_start_nxt = now_time;
      end
    end else if (!latched_pre) begin
      if (cdir != sdsg_pkg::DIR_STOP && !sdsg_pkg::at_end(cdir, limit_state) && timed_out) begin
        retries_nxt      = retries_inc;
        window_start_nxt = now_time;
      end else begin
        odir  = cdir;
        oduty = cduty;
      end
    end

    if (odir == sdsg_pkg::DIR_STOP) begin
      oduty = 8'd0;
    end

    res.drive_direction = odir;
    res.drive_duty      = oduty;
    res.stall_retries   = retries_nxt;
    res.latched         = retries_nxt >= cfg.retry_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dir_r   <= sdsg_pkg::DIR_STOP;
      window_start_r <= '0;
      retries_r      <= '0;
    end else if (step) begin
      active_dir_r   <= active_dir_nxt;
      window_start_r <= window_start_nxt;
      retries_r      <= retries_nxt;
    end
  end

endmodule
